### sv/lebuf_pkg.sv
`default_nettype none

package lebuf_pkg;

  localparam int CHAR_W = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] ERASE_RESET  = 8'd35;
  localparam logic [CHAR_W-1:0] KILL_RESET   = 8'd64;

  // Configuration register indexes
  localparam logic CFG_ERASE = 1'b0;
  localparam logic CFG_KILL  = 1'b1;

  // Command from the character front end to the line readout
  typedef struct packed {
    logic start;
    logic dropped;
  } drain_cmd_t;

  // One result item of an emitted line
  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              last;
    logic              empty;
    logic              ovf;
  } item_t;

endpackage

`default_nettype wire

### sv/lebuf_drain.sv
`default_nettype none

module lebuf_drain
  import lebuf_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
  input  wire logic [CHAR_W-1:0]             wr_data,
  input  wire drain_cmd_t                    cmd,
  input  wire logic [$clog2(LINE_DEPTH+1)-1:0] line_len,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output item_t                              out_item
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);

  typedef enum logic [1:0] {
    DR_IDLE = 2'b01,
    DR_READ = 2'b10
  } dr_state_t;

  dr_state_t        state;
  logic [CHAR_W-1:0] mem [LINE_DEPTH];
  logic [CHAR_W-1:0] mem_q;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    n_last;
  logic             line_dropped;
  logic             line_is_empty;

  // Metadata of the read in flight
  logic             pend_valid;
  logic             pend_last;
  logic             pend_empty;
  logic             pend_ovf;

  item_t            skid_item;
  logic             skid_valid;
  item_t            arr_item;
  logic             take;
  logic             issue;
  logic             issue_last;
  logic [1:0]       occ;

  assign busy = (state == DR_READ);
  assign take = out_valid & out_ready;
  assign occ  = 2'({1'b0, out_valid}) + 2'({1'b0, skid_valid}) + 2'({1'b0, pend_valid});

  // Issue a read only when the two output slots can absorb it
  assign issue      = busy && ((occ < 2'd2) || (take && (occ == 2'd2)));
  assign issue_last = (rd_idx == n_last);

  assign arr_item.data  = pend_empty ? '0 : mem_q;
  assign arr_item.last  = pend_last;
  assign arr_item.empty = pend_empty;
  assign arr_item.ovf   = pend_ovf;

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      mem_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // Sequence reads over the stored line
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= DR_IDLE;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue;
      case (state)
        DR_IDLE: begin
          if (cmd.start) begin
            state <= DR_READ;
          end
        end
        DR_READ: begin
          if (issue && issue_last) begin
            state <= DR_IDLE;
          end
        end
        default: begin
          state <= DR_IDLE;
        end
      endcase
    end
  end

  // Latch line length and flags at the start, advance the read index
  always_ff @(posedge clk) begin
    if (!busy && cmd.start) begin
      rd_idx        <= '0;
      line_dropped  <= cmd.dropped;
      line_is_empty <= (line_len == '0);
      n_last        <= (line_len == '0) ? '0 : CW'(line_len - CW'(1));
    end else if (issue) begin
      rd_idx <= CW'(rd_idx + CW'(1));
    end
    if (issue) begin
      pend_last  <= issue_last;
      pend_empty <= line_is_empty;
      pend_ovf   <= line_dropped;
    end
  end

  // Two-slot output queue: output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= pend_valid;
      end else begin
        out_valid <= pend_valid;
      end
    end else if (!out_valid) begin
      out_valid <= pend_valid;
    end else if (pend_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_item  <= skid_item;
        skid_item <= arr_item;
      end else begin
        out_item <= arr_item;
      end
    end else if (!out_valid) begin
      out_item <= arr_item;
    end else if (pend_valid) begin
      skid_item <= arr_item;
    end
  end

endmodule

`default_nettype wire

### sv/line_edit_buffer_top.sv
// Line edit buffer.
// Input channel (in_valid/in_ready, func, character) takes one transaction per
// cycle while no line is being read out. Plain characters are pushed into a
// LINE_DEPTH-entry line store, erase_char pops the last one, kill_char empties
// the store, and a character beyond the store depth is dropped and flagged.
// Newline (code 10), or end of input (func = 1) while a line is open, emits the
// line on the output channel (out_valid/out_ready, out_char, line_last,
// line_empty, overflow): one transaction per stored character, first to last,
// or a single empty-line transaction.
// A line end holds in_ready low while the store is read. After the line end
// is taken, the readout state is entered, each read goes through the registered
// read port of the store and then the output register, and results follow one
// per cycle while the receiver is ready, paced by the single read port of the
// store. A stalled receiver holds the results in a two-entry output queue and
// pauses the reads; input stays stalled until all reads of the line are issued.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is erase_char, index 1 is kill_char.
// Reset clears the fill count, line state and output queue and restores the
// erase and kill codes; the store contents are not cleared.
`default_nettype none

module line_edit_buffer_top
  import lebuf_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CHAR_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [CHAR_W-1:0] character,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   line_last,
  output logic                   line_empty,
  output logic                   overflow
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

  logic [CHAR_W-1:0] erase_char;
  logic [CHAR_W-1:0] kill_char;
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     fill_count_next;
  logic              line_open;
  logic              line_open_next;
  logic              dropped_flag;
  logic              dropped_flag_next;

  logic              in_take;
  logic              line_end;
  logic              wr_en;
  logic              busy;
  drain_cmd_t        cmd;
  item_t             out_item;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_take   = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char <= ERASE_RESET;
      kill_char  <= KILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ERASE: erase_char <= cfg_data;
        CFG_KILL:  kill_char  <= cfg_data;
        default:   erase_char <= erase_char;
      endcase
    end
  end

  // Classify the incoming transaction and update the line state
  always_comb begin
    fill_count_next   = fill_count;
    line_open_next    = line_open;
    dropped_flag_next = dropped_flag;
    line_end          = 1'b0;
    wr_en             = 1'b0;
    if (in_take) begin
      if (func) begin
        line_end = line_open;
      end else if (character == NEWLINE_CODE) begin
        line_end = 1'b1;
      end else begin
        line_open_next = 1'b1;
        if (character == erase_char) begin
          if (fill_count != '0) begin
            fill_count_next = CW'(fill_count - CW'(1));
          end
        end else if (character == kill_char) begin
          fill_count_next = '0;
        end else if (fill_count < DEPTH_C) begin
          wr_en           = 1'b1;
          fill_count_next = CW'(fill_count + CW'(1));
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
      if (line_end) begin
        fill_count_next   = '0;
        line_open_next    = 1'b0;
        dropped_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      line_open    <= 1'b0;
      dropped_flag <= 1'b0;
    end else begin
      fill_count   <= fill_count_next;
      line_open    <= line_open_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  assign cmd.start   = line_end;
  assign cmd.dropped = dropped_flag;

  lebuf_drain #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (fill_count[AW-1:0]),
    .wr_data  (character),
    .cmd      (cmd),
    .line_len (fill_count),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  assign out_char   = out_item.data;
  assign line_last  = out_item.last;
  assign line_empty = out_item.empty;
  assign overflow   = out_item.ovf;

`ifndef SYNTHESIS
  // Fill count never exceeds the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_C)
    else $error("fill_count beyond line depth");

  // A line end clears the line state and starts the readout
  a_line_end_clear: assert property (@(posedge clk) disable iff (rst)
    line_end |=> (fill_count == '0) && !line_open && !dropped_flag && busy)
    else $error("line end did not clear the line state");

  // An empty-line result is always the final one of its line
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_empty |-> line_last && (out_char == '0))
    else $error("empty-line result malformed");

  // No store write while the line is being read out
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("store written during readout");
`endif

endmodule

`default_nettype wire
